@@ src/crg_pkg.sv @@
`default_nettype none
package crg_pkg;

  localparam int unsigned VERIFIED_DEPTH = 64;
  localparam int unsigned POS_W = 40;
  localparam int unsigned OFF_W = 16;
  localparam int unsigned CNT_W = $clog2(VERIFIED_DEPTH + 1);
  localparam int unsigned IDX_W = (VERIFIED_DEPTH > 1) ? $clog2(VERIFIED_DEPTH) : 1;
  localparam int unsigned IN_DATA_W = 3 * POS_W + 4 * OFF_W;
  localparam int unsigned OUT_DATA_W = 3 * POS_W + 3 * OFF_W;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CAND  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRK_SUB,
    ST_BRK_CMP,
    ST_SK_RD,
    ST_SK_CMP,
    ST_CV1,
    ST_CV2,
    ST_BE_SUB,
    ST_CL_DONE,
    ST_OPEN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] vbegin;
    logic [POS_W-1:0] vend;
  } vent_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    vent_t            data;
  } vt_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } vt_rd_t;

endpackage
`default_nettype wire

@@ src/crg_vtab.sv @@
`default_nettype none
module crg_vtab (
  input  wire                 clk_i,
  input  wire crg_pkg::vt_wr_t wr_i,
  input  wire crg_pkg::vt_rd_t rd_i,
  output crg_pkg::vent_t      rdata_o
);

  crg_pkg::vent_t mem [crg_pkg::VERIFIED_DEPTH];
  crg_pkg::vent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/crg_sub.sv @@
`default_nettype none
module crg_sub (
  input  wire [crg_pkg::POS_W-1:0]  a_i,
  input  wire [crg_pkg::POS_W-1:0]  b_i,
  output logic [crg_pkg::POS_W-1:0] diff_o,
  output logic                      borrow_o
);

  logic [crg_pkg::POS_W:0] full;

  // borrow set means a < b
  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[crg_pkg::POS_W-1:0];
  assign borrow_o = full[crg_pkg::POS_W];

endmodule
`default_nettype wire

@@ src/candidate_region_grouper.sv @@
// Clear, load and unused words are handled in idle; a candidate passes a break subtract and,
// with an open group, a break compare, then extends or opens the group. Closing a group walks the
// cursor past verified entries ending at or before its begin (amortized, since it only moves forward),
// checks containment and forms the base end; a flush first pushes a pending break result.
// One word at a time; a result waits while the output register is still full.
// Reset: table empty, cursor zero, no open group, max_group_delta zero, no result pending.
`default_nettype none
module candidate_region_grouper (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_wr_en_i,
  input  wire  [15:0]  cfg_wr_data_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // seq_id, begin_pos, end_pos, base_begin_off, base_end_off, trim_left, trim_right
  input  wire  [183:0] s_axis_tdata,
  // operation
  input  wire  [1:0]   s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // region_begin, region_end, region_base_begin, region_base_end,
  // region_trim_left, region_trim_right
  output logic [167:0] m_axis_tdata,
  // trim_flag
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned PW = crg_pkg::POS_W;
  localparam int unsigned OW = crg_pkg::OFF_W;
  localparam int unsigned CW = crg_pkg::CNT_W;
  localparam int unsigned IW = crg_pkg::IDX_W;

  typedef struct packed {
    logic [PW-1:0] rbegin;
    logic [PW-1:0] rend;
    logic [OW-1:0] bbegin;
    logic [PW-1:0] bend;
    logic [OW-1:0] tl;
    logic [OW-1:0] tr;
  } res_t;

  crg_pkg::state_e state_q, state_d;

  logic [OW-1:0] delta_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cur_q, cur_d;
  logic          gopen_q, gopen_d;
  logic          phase_fin_q, phase_fin_d;
  logic          res_vld_q, res_vld_d;
  logic          push_last_q, push_last_d;
  logic          ret_be_q, ret_be_d;
  logic          m_valid_q, m_valid_d;

  logic [PW-1:0] in_seq_q, in_begin_q, in_end_q;
  logic [OW-1:0] in_bbo_q, in_beo_q, in_tl_q, in_tr_q;
  logic          in_fin_q;

  logic [PW-1:0] gseq_q, gbegin_q, glast_end_q, glbe_q, diff_q;
  logic [OW-1:0] gbb_q, gtl_q, gtr_q;
  res_t          res_q, m_q;
  logic          m_last_q;

  logic          in_load, open_load, last_load, diff_load, res_load, out_load;
  logic [PW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_borrow;

  crg_pkg::vt_wr_t vt_wr;
  crg_pkg::vt_rd_t vt_rd;
  crg_pkg::vent_t  vt_rdata;
  crg_pkg::op_e    op;

  assign op     = crg_pkg::op_e'(s_axis_tuser);

  crg_vtab u_vtab (
    .clk_i   (clk_i),
    .wr_i    (vt_wr),
    .rd_i    (vt_rd),
    .rdata_o (vt_rdata)
  );

  crg_sub u_sub (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      crg_pkg::ST_BRK_SUB: begin
        alu_a = in_begin_q;
        alu_b = gbegin_q;
      end
      crg_pkg::ST_BRK_CMP: begin
        alu_a = PW'(delta_q);
        alu_b = diff_q;
      end
      crg_pkg::ST_SK_CMP: begin
        alu_a = gbegin_q;
        alu_b = vt_rdata.vend;
      end
      crg_pkg::ST_CV1: begin
        alu_a = gbegin_q;
        alu_b = vt_rdata.vbegin;
      end
      crg_pkg::ST_CV2: begin
        alu_a = vt_rdata.vend;
        alu_b = glast_end_q;
      end
      crg_pkg::ST_BE_SUB: begin
        alu_a = glbe_q;
        alu_b = gbegin_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cur_d         = cur_q;
    gopen_d       = gopen_q;
    phase_fin_d   = phase_fin_q;
    res_vld_d     = res_vld_q;
    push_last_d   = push_last_q;
    ret_be_d      = ret_be_q;
    s_axis_tready = 1'b0;
    in_load       = 1'b0;
    open_load     = 1'b0;
    last_load     = 1'b0;
    diff_load     = 1'b0;
    res_load      = 1'b0;
    out_load      = 1'b0;
    vt_wr.en      = 1'b0;
    vt_wr.addr    = cnt_q[IW-1:0];
    vt_wr.data    = '{vbegin: s_axis_tdata[2*PW-1:PW], vend: s_axis_tdata[3*PW-1:2*PW]};
    vt_rd.en      = 1'b0;
    vt_rd.addr    = cur_q[IW-1:0];

    case (state_q)
      crg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          in_load = 1'b1;
          case (op)
            crg_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              cur_d   = '0;
              gopen_d = 1'b0;
            end
            crg_pkg::OP_LOAD: begin
              if (cnt_q < CW'(crg_pkg::VERIFIED_DEPTH)) begin
                vt_wr.en = 1'b1;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            crg_pkg::OP_CAND: state_d = crg_pkg::ST_BRK_SUB;
            default: begin
            end
          endcase
        end
      end
      crg_pkg::ST_BRK_SUB: begin
        diff_load = 1'b1;
        state_d   = gopen_q ? crg_pkg::ST_BRK_CMP : crg_pkg::ST_OPEN;
      end
      crg_pkg::ST_BRK_CMP: begin
        if ((in_seq_q != gseq_q) || alu_borrow) begin
          gopen_d     = 1'b0;
          phase_fin_d = 1'b0;
          state_d     = crg_pkg::ST_SK_RD;
        end else begin
          state_d = crg_pkg::ST_OPEN;
        end
      end
      crg_pkg::ST_SK_RD: begin
        if (cur_q < cnt_q) begin
          vt_rd.en = 1'b1;
          state_d  = crg_pkg::ST_SK_CMP;
        end else begin
          state_d = crg_pkg::ST_BE_SUB;
        end
      end
      crg_pkg::ST_SK_CMP: begin
        if (!alu_borrow) begin
          cur_d   = cur_q + 1'b1;
          state_d = crg_pkg::ST_SK_RD;
        end else begin
          state_d = crg_pkg::ST_CV1;
        end
      end
      crg_pkg::ST_CV1: begin
        state_d = alu_borrow ? crg_pkg::ST_BE_SUB : crg_pkg::ST_CV2;
      end
      crg_pkg::ST_CV2: begin
        // contained in a verified region: drop the group
        state_d = alu_borrow ? crg_pkg::ST_BE_SUB : crg_pkg::ST_CL_DONE;
      end
      crg_pkg::ST_BE_SUB: begin
        if (phase_fin_q && res_vld_q) begin
          push_last_d = 1'b0;
          ret_be_d    = 1'b1;
          state_d     = crg_pkg::ST_PUSH;
        end else begin
          res_load  = 1'b1;
          res_vld_d = 1'b1;
          if (!phase_fin_q) begin
            state_d = crg_pkg::ST_OPEN;
          end else begin
            cur_d       = '0;
            push_last_d = 1'b1;
            ret_be_d    = 1'b0;
            state_d     = crg_pkg::ST_PUSH;
          end
        end
      end
      crg_pkg::ST_CL_DONE: begin
        if (!phase_fin_q) begin
          state_d = crg_pkg::ST_OPEN;
        end else begin
          cur_d = '0;
          if (res_vld_q) begin
            push_last_d = 1'b1;
            ret_be_d    = 1'b0;
            state_d     = crg_pkg::ST_PUSH;
          end else begin
            state_d = crg_pkg::ST_IDLE;
          end
        end
      end
      crg_pkg::ST_OPEN: begin
        last_load = 1'b1;
        if (!gopen_q) begin
          open_load = 1'b1;
          gopen_d   = 1'b1;
        end
        if (in_fin_q) begin
          gopen_d     = 1'b0;
          phase_fin_d = 1'b1;
          state_d     = crg_pkg::ST_SK_RD;
        end else if (res_vld_q) begin
          push_last_d = 1'b1;
          ret_be_d    = 1'b0;
          state_d     = crg_pkg::ST_PUSH;
        end else begin
          state_d = crg_pkg::ST_IDLE;
        end
      end
      crg_pkg::ST_PUSH: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          res_vld_d = 1'b0;
          state_d   = ret_be_q ? crg_pkg::ST_BE_SUB : crg_pkg::ST_IDLE;
        end
      end
      default: state_d = crg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q     <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      gopen_q     <= 1'b0;
      phase_fin_q <= 1'b0;
      res_vld_q   <= 1'b0;
      push_last_q <= 1'b0;
      ret_be_q    <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        delta_q <= cfg_wr_data_i;
      end
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      gopen_q     <= gopen_d;
      phase_fin_q <= phase_fin_d;
      res_vld_q   <= res_vld_d;
      push_last_q <= push_last_d;
      ret_be_q    <= ret_be_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_seq_q   <= s_axis_tdata[PW-1:0];
      in_begin_q <= s_axis_tdata[2*PW-1:PW];
      in_end_q   <= s_axis_tdata[3*PW-1:2*PW];
      in_bbo_q   <= s_axis_tdata[3*PW+OW-1:3*PW];
      in_beo_q   <= s_axis_tdata[3*PW+2*OW-1:3*PW+OW];
      in_tl_q    <= s_axis_tdata[3*PW+3*OW-1:3*PW+2*OW];
      in_tr_q    <= s_axis_tdata[3*PW+4*OW-1:3*PW+3*OW];
      in_fin_q   <= s_axis_tlast;
    end
    if (diff_load) begin
      diff_q <= alu_diff;
    end
    if (open_load) begin
      gseq_q   <= in_seq_q;
      gbegin_q <= in_begin_q;
      gbb_q    <= in_bbo_q;
      gtl_q    <= in_tl_q;
      gtr_q    <= in_tr_q;
    end
    if (last_load) begin
      glast_end_q <= in_end_q;
      glbe_q      <= in_begin_q + PW'(in_beo_q);
    end
    if (res_load) begin
      res_q <= '{rbegin: gbegin_q, rend: glast_end_q, bbegin: gbb_q,
                 bend: alu_diff, tl: gtl_q, tr: gtr_q};
    end
    if (out_load) begin
      m_q      <= res_q;
      m_last_q <= push_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_q.tr, m_q.tl, m_q.bend, m_q.bbegin, m_q.rend, m_q.rbegin};
  assign m_axis_tuser  = (m_q.tl != '0) || (m_q.tr != '0);
  assign m_axis_tlast  = m_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(crg_pkg::VERIFIED_DEPTH))
    else $error("verified count beyond table depth");

  a_cur_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= cnt_q)
    else $error("cursor ran past verified count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output register overwritten while full");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crg_pkg::ST_IDLE) |-> !res_vld_q)
    else $error("result left pending in idle");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct {
    crg_pkg::op_e op;
    logic [39:0] seq;
    logic [39:0] bpos;
    logic [39:0] epos;
    logic [15:0] bbo;
    logic [15:0] beo;
    logic [15:0] tl;
    logic [15:0] tr;
    logic        fin;
  } word_t;

  typedef struct {
    logic [39:0] rbeg;
    logic [39:0] rend;
    logic [15:0] rbb;
    logic [39:0] rbe;
    logic [15:0] rtl;
    logic [15:0] rtr;
    logic        trimmed;
    logic        last;
  } region_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_wr_en_i;
  logic [15:0]  cfg_wr_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [167:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  candidate_region_grouper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // grouper state mirror
  logic [39:0] vt_begin [crg_pkg::VERIFIED_DEPTH];
  logic [39:0] vt_end [crg_pkg::VERIFIED_DEPTH];
  int unsigned vt_count;
  int unsigned vt_cursor;
  logic        grp_open;
  logic [39:0] grp_seq;
  logic [39:0] grp_begin;
  logic [15:0] grp_bbo;
  logic [15:0] grp_tl;
  logic [15:0] grp_tr;
  logic [39:0] grp_last_end;
  logic [39:0] grp_last_be;
  logic [15:0] max_delta;

  region_t     region_q [$];
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned idle_cycles;
  int unsigned sink_hold;
  bit          src_quiet;
  bit          snk_quiet;

  initial begin
    clk_i = 1'b0;
  end
  always #4 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic logic [39:0] rand40();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[39:0];
  endfunction

  function automatic word_t mk(input crg_pkg::op_e op, input logic [39:0] seq,
                               input logic [39:0] b, input logic [39:0] e,
                               input logic fin);
    word_t w;
    w.op   = op;
    w.seq  = seq;
    w.bpos = b;
    w.epos = e;
    w.fin  = fin;
    w.bbo  = 16'($urandom);
    w.beo  = 16'($urandom);
    w.tl   = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    w.tr   = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    return w;
  endfunction

  function automatic void wipe_batch();
    vt_count     = 0;
    vt_cursor    = 0;
    grp_open     = 1'b0;
    grp_seq      = '0;
    grp_begin    = '0;
    grp_bbo      = '0;
    grp_tl       = '0;
    grp_tr       = '0;
    grp_last_end = '0;
    grp_last_be  = '0;
  endfunction

  function automatic bit shut_group(output region_t r);
    bit covered;
    covered = 1'b0;
    r = '{default: '0};
    if (!grp_open) return 1'b0;
    grp_open = 1'b0;
    while (vt_cursor < vt_count && vt_end[crg_pkg::IDX_W'(vt_cursor)] <= grp_begin)
      vt_cursor++;
    if (vt_cursor < vt_count)
      covered = (vt_begin[crg_pkg::IDX_W'(vt_cursor)] <= grp_begin) &&
                (grp_last_end <= vt_end[crg_pkg::IDX_W'(vt_cursor)]);
    if (covered) return 1'b0;
    r.rbeg    = grp_begin;
    r.rend    = grp_last_end;
    r.rbb     = grp_bbo;
    r.rbe     = grp_last_be - grp_begin;
    r.rtl     = grp_tl;
    r.rtr     = grp_tr;
    r.trimmed = (grp_tl != 0) || (grp_tr != 0);
    r.last    = 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_regions(input word_t w);
    region_t     r [2];
    region_t     one;
    int          n;
    logic [39:0] span;
    n = 0;
    case (w.op)
      crg_pkg::OP_CLEAR: wipe_batch();
      crg_pkg::OP_LOAD: begin
        if (vt_count < crg_pkg::VERIFIED_DEPTH) begin
          vt_begin[crg_pkg::IDX_W'(vt_count)] = w.bpos;
          vt_end[crg_pkg::IDX_W'(vt_count)]   = w.epos;
          vt_count++;
        end
      end
      crg_pkg::OP_CAND: begin
        span = w.bpos - grp_begin;
        if (grp_open && (w.seq != grp_seq || span > {24'd0, max_delta})) begin
          if (shut_group(one)) begin
            r[1'(n)] = one;
            n++;
          end
        end
        if (!grp_open) begin
          grp_open  = 1'b1;
          grp_seq   = w.seq;
          grp_begin = w.bpos;
          grp_bbo   = w.bbo;
          grp_tl    = w.tl;
          grp_tr    = w.tr;
        end
        grp_last_end = w.epos;
        grp_last_be  = w.bpos + {24'd0, w.beo};
        if (w.fin) begin
          if (shut_group(one)) begin
            r[1'(n)] = one;
            n++;
          end
          vt_cursor = 0;
        end
      end
      default: ;
    endcase
    if (n > 0) r[1'(n-1)].last = 1'b1;
    for (int i = 0; i < n; i++) region_q.push_back(r[1'(i)]);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input word_t w);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.tr, w.tl, w.beo, w.bbo, w.epos, w.bpos, w.seq};
    s_axis_tuser  <= w.op;
    s_axis_tlast  <= w.fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_regions(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (region_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_delta(input logic [15:0] v);
    cfg_wr_data_i <= v;
    cfg_wr_en_i   <= 1'b1;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    max_delta = v;
  endtask

  task automatic check_field(input string name, input logic [39:0] got,
                             input logic [39:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    region_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (region_q.size() == 0) begin
        flag_error("region word with nothing expected");
      end else begin
        want = region_q.pop_front();
        check_field("region_begin", m_axis_tdata[39:0], want.rbeg);
        check_field("region_end", m_axis_tdata[79:40], want.rend);
        check_field("region_base_begin", {24'd0, m_axis_tdata[95:80]}, {24'd0, want.rbb});
        check_field("region_base_end", m_axis_tdata[135:96], want.rbe);
        check_field("region_trim_left", {24'd0, m_axis_tdata[151:136]}, {24'd0, want.rtl});
        check_field("region_trim_right", {24'd0, m_axis_tdata[167:152]}, {24'd0, want.rtr});
        check_field("trim_flag", {39'd0, m_axis_tuser}, {39'd0, want.trimmed});
        check_field("last_of_run", {39'd0, m_axis_tlast}, {39'd0, want.last});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("candidate_region_grouper test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sink
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end
      gap = snk_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic test_directed();
    word_t w;
    write_delta(16'd100);
    send_word(mk(crg_pkg::OP_CLEAR, rand40(), rand40(), rand40(), 1'b1));
    send_word(mk(crg_pkg::OP_LOAD, rand40(), 40'd1000, 40'd2000, 1'b0));
    send_word(mk(crg_pkg::OP_LOAD, rand40(), 40'd3000, 40'd3500, 1'b1));
    send_word(mk(crg_pkg::OP_LOAD, rand40(), 40'd5000, 40'd6000, 1'b0));
    send_word(mk(crg_pkg::OP_NONE, rand40(), rand40(), rand40(), 1'b1));
    // group inside the first verified region is dropped
    send_word(mk(crg_pkg::OP_CAND, 40'hA, 40'd1100, 40'd1200, 1'b0));
    send_word(mk(crg_pkg::OP_CAND, 40'hA, 40'd1150, 40'd1900, 1'b0));
    send_word(mk(crg_pkg::OP_CAND, 40'hB, 40'd1160, 40'd2100, 1'b0));
    // one past the distance, then exactly at it
    send_word(mk(crg_pkg::OP_CAND, 40'hB, 40'd1261, 40'd1270, 1'b0));
    send_word(mk(crg_pkg::OP_CAND, 40'hB, 40'd1361, 40'd4000, 1'b1));
    // break and flush in one word
    send_word(mk(crg_pkg::OP_CAND, 40'hC, 40'd2500, 40'd2600, 1'b0));
    send_word(mk(crg_pkg::OP_CAND, 40'hD, 40'd2510, 40'd2520, 1'b1));
    // earlier begin wraps to a large distance
    send_word(mk(crg_pkg::OP_CAND, 40'hE, 40'd5000, 40'd5100, 1'b0));
    send_word(mk(crg_pkg::OP_CAND, 40'hE, 40'd4000, 40'd4100, 1'b0));
    send_word(mk(crg_pkg::OP_CLEAR, rand40(), rand40(), rand40(), 1'b0));
    drain_all();
    write_delta(16'hFFFF);
    w = mk(crg_pkg::OP_CAND, '1, '1, '1, 1'b0);
    w.bbo = '1;
    w.beo = '1;
    w.tl  = '1;
    w.tr  = '1;
    send_word(w);
    w = mk(crg_pkg::OP_CAND, '1, '0, '0, 1'b1);
    w.bbo = '0;
    w.beo = '1;
    w.tl  = '0;
    w.tr  = '0;
    send_word(w);
    drain_all();
    write_delta(16'd0);
    w = mk(crg_pkg::OP_CAND, '0, '0, '0, 1'b0);
    w.tl = '0;
    w.tr = '0;
    send_word(w);
    w = mk(crg_pkg::OP_CAND, '0, '0, 40'd9, 1'b0);
    w.tl = 16'd5;
    send_word(w);
    w = mk(crg_pkg::OP_CAND, '0, 40'd1, 40'd3, 1'b1);
    w.tl = '0;
    w.tr = 16'd7;
    send_word(w);
    drain_all();
  endtask

  task automatic test_table_full();
    logic [39:0] b;
    write_delta(16'd50);
    send_word(mk(crg_pkg::OP_CLEAR, rand40(), rand40(), rand40(), 1'b0));
    for (int k = 0; k < crg_pkg::VERIFIED_DEPTH + 2; k++) begin
      b = 40'd10000 + 40'(100 * k);
      send_word(mk(crg_pkg::OP_LOAD, rand40(), b, b + 40'd80, 1'b0));
    end
    // covered by the last stored entry, then past the dropped loads
    send_word(mk(crg_pkg::OP_CAND, 40'd1, 40'd16310, 40'd16350, 1'b0));
    send_word(mk(crg_pkg::OP_CAND, 40'd2, 40'd16410, 40'd16420, 1'b1));
    send_word(mk(crg_pkg::OP_CAND, 40'd3, 40'd10005, 40'd10050, 1'b1));
    send_word(mk(crg_pkg::OP_CAND, 40'd3, 40'd10090, 40'd10095, 1'b1));
    drain_all();
  endtask

  task automatic test_backpressure();
    send_word(mk(crg_pkg::OP_CLEAR, rand40(), rand40(), rand40(), 1'b0));
    src_quiet = 1'b1;
    sink_hold = 400;
    for (int k = 0; k < 40; k++)
      send_word(mk(crg_pkg::OP_CAND, 40'(k), 40'(10 * k), 40'(10 * k + 5), k == 39));
    src_quiet = 1'b0;
    drain_all();
  endtask

  task automatic test_random_batches();
    int unsigned goal;
    int unsigned batch;
    int unsigned nver;
    int unsigned ncand;
    logic [39:0] pos;
    logic [39:0] b;
    logic [39:0] e;
    logic [39:0] cur;
    logic [39:0] cseq;
    logic [39:0] seqs [4];
    goal  = 650;
    batch = 0;
    while (words_sent < goal) begin
      if (batch % 6 == 0) begin
        drain_all();
        case ($urandom_range(0, 3))
          0: write_delta(16'd0);
          1: write_delta(16'hFFFF);
          2: write_delta(16'($urandom_range(1, 400)));
          default: write_delta(16'($urandom));
        endcase
      end
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0)
        send_word(mk(crg_pkg::OP_CLEAR, rand40(), rand40(), rand40(), 1'($urandom)));
      nver = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(0, 10);
      pos = rand40();
      cur = pos;
      for (int k = 0; k < nver; k++) begin
        b = pos + 40'($urandom_range(0, 200));
        e = b + 40'($urandom_range(1, 300));
        send_word(mk(crg_pkg::OP_LOAD, rand40(), b, e, 1'($urandom)));
        pos = e;
      end
      for (int k = 0; k < 4; k++) seqs[2'(k)] = $urandom_range(0, 1) ? rand40() : 40'(k);
      cseq  = seqs[0];
      ncand = $urandom_range(1, 24);
      for (int k = 0; k < ncand; k++) begin
        cur = cur + 40'($urandom_range(0, 150));
        if ($urandom_range(0, 3) == 0) cseq = seqs[2'($urandom_range(0, 3))];
        case ($urandom_range(0, 19))
          0: send_word(mk(crg_pkg::OP_NONE, rand40(), rand40(), rand40(), 1'($urandom)));
          1: send_word(mk(crg_pkg::OP_LOAD, rand40(), cur,
                          cur + 40'($urandom_range(0, 500)), 1'b0));
          2: send_word(mk(crg_pkg::OP_CAND, cseq, rand40(), rand40(), 1'b0));
          default: ;
        endcase
        send_word(mk(crg_pkg::OP_CAND, cseq, cur, cur + 40'($urandom_range(0, 250)),
                     (k == ncand - 1) && ($urandom_range(0, 9) != 0)));
      end
      batch++;
    end
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = crg_pkg::OP_CLEAR;
    s_axis_tlast  = 1'b0;
    err_count     = 0;
    words_sent    = 0;
    idle_cycles   = 0;
    sink_hold     = 0;
    src_quiet     = 1'b0;
    snk_quiet     = 1'b0;
    max_delta     = '0;
    wipe_batch();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random_batches();
    drain_all();
    if (region_q.size() != 0) flag_error("region words missing at end");
    if (err_count == 0) begin
      $display("candidate_region_grouper test passed");
    end else begin
      $display("candidate_region_grouper test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/crg_pkg.sv
src/crg_vtab.sv
src/crg_sub.sv
src/candidate_region_grouper.sv
tb/sv/tb_top.sv
